// File: design/afcu_pkg.sv
// ----------------------------------------------------------------------------
// afcu_pkg
// Shared types and constants of the attractor force and consume unit.
// ----------------------------------------------------------------------------
package afcu_pkg;

  localparam int unsigned COORD_W  = 24;
  localparam int unsigned DIFF_W   = 25;
  localparam int unsigned DIST2_W  = 49;
  localparam int unsigned RADSQ_W  = 47;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned HEALTH_W = 16;
  localparam int unsigned HCOUNT_W = 18;
  localparam int unsigned HNOW_W   = 17;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned ROOT_W   = 24;
  localparam int unsigned CFG_IDX_W = 3;

  // item modes
  localparam logic [1:0] MODE_FORCE   = 2'd0;
  localparam logic [1:0] MODE_CONSUME = 2'd1;
  localparam logic [1:0] MODE_RESTORE = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ATTRACTOR_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ATTRACTOR_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ATTRACT_RSQ  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CONSUME_RSQ  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FORCE_GAIN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_HEALTH  = 3'd5;

  // register reset values
  localparam logic [RADSQ_W-1:0]  RST_ATTRACT_RSQ = 47'd1;
  localparam logic [GAIN_W-1:0]   RST_FORCE_GAIN  = 16'd256;
  localparam logic [HEALTH_W-1:0] RST_INIT_HEALTH = 16'd100;

  // control toward the engine
  typedef struct packed {
    logic start;
    logic force_en;
  } afcu_ctl_t;

  // status back from the engine
  typedef struct packed {
    logic               done;
    logic [DIST2_W-1:0] d2;
  } afcu_sts_t;

endpackage

// File: design/afcu_engine.sv
// ----------------------------------------------------------------------------
// afcu_engine
// Bit-serial arithmetic: squared distance, gain falloff, square root and
// per-axis scaling, one bit or one root digit per cycle.
// ----------------------------------------------------------------------------
module afcu_engine (
  input  logic                                clk,
  input  logic                                rst,
  input  afcu_pkg::afcu_ctl_t                 ctl,
  input  logic [afcu_pkg::COORD_W-1:0]        ax,
  input  logic [afcu_pkg::COORD_W-1:0]        ay,
  input  logic                                neg_x,
  input  logic                                neg_y,
  input  logic [afcu_pkg::RADSQ_W-1:0]        radius_sq,
  input  logic [afcu_pkg::GAIN_W-1:0]         gain,
  output afcu_pkg::afcu_sts_t                 sts,
  output logic signed [afcu_pkg::COORD_W-1:0] force_x,
  output logic signed [afcu_pkg::COORD_W-1:0] force_y
);
  import afcu_pkg::*;

  localparam logic [4:0] LAST_COORD = 5'(COORD_W - 1);
  localparam logic [4:0] LAST_FRAC  = 5'(FRAC_W - 1);
  localparam logic [4:0] LAST_ROOT  = 5'(ROOT_W - 1);

  typedef enum logic [3:0] {
    E_IDLE, E_SQ, E_CHK, E_DIV_T, E_MUL_M, E_SQRT, E_MUL_P, E_DIV_Q, E_DONE
  } est_t;

  est_t st;
  logic [4:0]         cnt;
  logic               axis;
  logic               done;
  logic [DIST2_W-1:0] d2;
  // shift-add multiplier
  logic [DIST2_W-1:0] acc;
  logic [DIST2_W-1:0] mcand;
  logic [COORD_W-1:0] mplier;
  // restoring divider
  logic [RADSQ_W-1:0] rem;
  logic [RADSQ_W-1:0] dvs;
  logic [FRAC_W-1:0]  nb;
  logic [FRAC_W-1:0]  quo;
  // digit-by-digit square root
  logic [47:0]        sr;
  logic [25:0]        srem;
  logic [ROOT_W-1:0]  root;
  logic [FRAC_W-1:0]  mag;
  logic [ROOT_W-1:0]  len;
  logic signed [COORD_W-1:0] fx;
  logic signed [COORD_W-1:0] fy;

  // step logic
  logic [DIST2_W-1:0] acc_next;
  logic [RADSQ_W:0]   rem_sh;
  logic               div_ge;
  logic [RADSQ_W-1:0] rem_next;
  logic [FRAC_W-1:0]  quo_next;
  logic [26:0]        rr;
  logic [26:0]        trial;
  logic               sq_ge;
  logic [ROOT_W-1:0]  root_next;
  logic [25:0]        srem_next;
  logic [COORD_W-1:0] qmag;
  logic [COORD_W-1:0] signed_q;

  always_comb begin
    acc_next  = mplier[0] ? acc + mcand : acc;
    rem_sh    = {rem, nb[FRAC_W-1]};
    div_ge    = rem_sh >= {1'b0, dvs};
    rem_next  = div_ge ? RADSQ_W'(rem_sh - {1'b0, dvs}) : rem_sh[RADSQ_W-1:0];
    quo_next  = {quo[FRAC_W-2:0], div_ge};
    rr        = {srem[24:0], sr[47:46]};
    trial     = {1'b0, root, 2'b01};
    sq_ge     = rr >= trial;
    srem_next = sq_ge ? 26'(rr - trial) : rr[25:0];
    root_next = {root[ROOT_W-2:0], sq_ge};
    qmag      = {8'd0, quo_next};
    signed_q  = (axis ? neg_y : neg_x) ? COORD_W'(-qmag) : qmag;
  end

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= E_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (st)
        E_IDLE: begin
          if (ctl.start) begin
            acc    <= '0;
            mcand  <= {25'd0, ax};
            mplier <= ax;
            cnt    <= '0;
            axis   <= 1'b0;
            st     <= E_SQ;
          end
        end
        E_SQ: begin
          acc    <= acc_next;
          mcand  <= {mcand[DIST2_W-2:0], 1'b0};
          mplier <= {1'b0, mplier[COORD_W-1:1]};
          cnt    <= cnt + 5'd1;
          if (cnt == LAST_COORD) begin
            cnt <= '0;
            if (!axis) begin
              axis   <= 1'b1;
              mcand  <= {25'd0, ay};
              mplier <= ay;
            end else begin
              st <= E_CHK;
            end
          end
        end
        E_CHK: begin
          d2 <= acc;
          if (ctl.force_en && acc != '0 && acc < {2'b00, radius_sq}) begin
            rem <= RADSQ_W'({2'b00, radius_sq} - acc);
            dvs <= radius_sq;
            nb  <= '0;
            quo <= '0;
            cnt <= '0;
            st  <= E_DIV_T;
          end else begin
            fx <= '0;
            fy <= '0;
            st <= E_DONE;
          end
        end
        E_DIV_T: begin
          rem <= rem_next;
          quo <= quo_next;
          nb  <= {nb[FRAC_W-2:0], 1'b0};
          cnt <= cnt + 5'd1;
          if (cnt == LAST_FRAC) begin
            acc    <= '0;
            mcand  <= {33'd0, quo_next};
            mplier <= {8'd0, gain};
            cnt    <= '0;
            st     <= E_MUL_M;
          end
        end
        E_MUL_M: begin
          acc    <= acc_next;
          mcand  <= {mcand[DIST2_W-2:0], 1'b0};
          mplier <= {1'b0, mplier[COORD_W-1:1]};
          cnt    <= cnt + 5'd1;
          if (cnt == LAST_FRAC) begin
            mag  <= acc_next[31:16];
            sr   <= {1'b0, d2[RADSQ_W-1:0]};
            srem <= '0;
            root <= '0;
            cnt  <= '0;
            st   <= E_SQRT;
          end
        end
        E_SQRT: begin
          sr   <= {sr[45:0], 2'b00};
          srem <= srem_next;
          root <= root_next;
          cnt  <= cnt + 5'd1;
          if (cnt == LAST_ROOT) begin
            len    <= root_next;
            axis   <= 1'b0;
            acc    <= '0;
            mcand  <= {33'd0, mag};
            mplier <= ax;
            cnt    <= '0;
            st     <= E_MUL_P;
          end
        end
        E_MUL_P: begin
          acc    <= acc_next;
          mcand  <= {mcand[DIST2_W-2:0], 1'b0};
          mplier <= {1'b0, mplier[COORD_W-1:1]};
          cnt    <= cnt + 5'd1;
          if (cnt == LAST_COORD) begin
            // quotient fits 16 bits, so the upper part already lies below len
            rem <= {23'd0, acc_next[39:16]};
            nb  <= acc_next[15:0];
            dvs <= {23'd0, len};
            quo <= '0;
            cnt <= '0;
            st  <= E_DIV_Q;
          end
        end
        E_DIV_Q: begin
          rem <= rem_next;
          quo <= quo_next;
          nb  <= {nb[FRAC_W-2:0], 1'b0};
          cnt <= cnt + 5'd1;
          if (cnt == LAST_FRAC) begin
            cnt <= '0;
            if (!axis) begin
              fx     <= signed_q;
              axis   <= 1'b1;
              acc    <= '0;
              mcand  <= {33'd0, mag};
              mplier <= ay;
              st     <= E_MUL_P;
            end else begin
              fy <= signed_q;
              st <= E_DONE;
            end
          end
        end
        E_DONE: begin
          done <= 1'b1;
          st   <= E_IDLE;
        end
        default: st <= E_IDLE;
      endcase
    end
  end

  assign sts.done = done;
  assign sts.d2   = d2;
  assign force_x  = fx;
  assign force_y  = fy;

endmodule

// File: design/attractor_force_and_consume_unit.sv
// ----------------------------------------------------------------------------
// attractor_force_and_consume_unit
// Point attractor with health: force queries, consume attempts and restore.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one item: tuser holds the mode, tdata the agent position and
//   the damage amount. m_* returns one result item per input item.
//   cfg_* writes a register by index; it is always ready, and the user must
//   write it only while the block is idle, which the block does not enforce.
// Sequence:
//   every item first forms the squared distance bit-serially; a force
//   query from an active attractor that lies inside the radius and not on
//   the attractor then runs a falloff division, a gain multiply, a square
//   root and for each axis a multiply and a division, all in the one serial
//   engine. s_tready rises again as the result is registered, so only one
//   item is in work at a time.
// Reset and stall:
//   rst loads register reset values, health 100 and the active flag.
//   A stalled m_tready holds the result; the next item may be taken and
//   worked on while it waits, and its result holds until the slot empties.
// ----------------------------------------------------------------------------
module attractor_force_and_consume_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // agent_x[23:0], agent_y[47:24], damage_amount[63:48]
  input  logic [63:0] s_tdata,
  // mode[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // force_x[23:0], force_y[47:24], consumed[48], still_active[49],
  // health_now[66:50], zero fill[71:67]
  output logic [71:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [afcu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [afcu_pkg::RADSQ_W-1:0]   cfg_data
);
  import afcu_pkg::*;

  typedef enum logic [1:0] {T_IDLE, T_RUN, T_DONE} tst_t;

  tst_t st;
  // configuration registers
  logic signed [COORD_W-1:0] attractor_x;
  logic signed [COORD_W-1:0] attractor_y;
  logic [RADSQ_W-1:0]  attract_rsq;
  logic [RADSQ_W-1:0]  consume_rsq;
  logic [GAIN_W-1:0]   force_gain;
  logic [HEALTH_W-1:0] init_health;
  // state
  logic signed [HCOUNT_W-1:0] health;
  logic                       active;
  // item registers
  logic [1:0]          mode;
  logic [HEALTH_W-1:0] damage;
  logic [COORD_W-1:0]  ax;
  logic [COORD_W-1:0]  ay;
  logic                neg_x;
  logic                neg_y;
  afcu_ctl_t           ctl;
  afcu_sts_t           sts;
  logic signed [COORD_W-1:0] eng_fx;
  logic signed [COORD_W-1:0] eng_fy;
  logic [71:0]         out_data;

  // item position differences
  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;
  logic [DIFF_W-1:0]        dx_abs;
  logic [DIFF_W-1:0]        dy_abs;
  // result logic
  logic                       hit;
  logic signed [HCOUNT_W-1:0] health_next;
  logic                       active_next;
  logic                       out_free;

  always_comb begin
    dx     = DIFF_W'(attractor_x) - DIFF_W'($signed(s_tdata[23:0]));
    dy     = DIFF_W'(attractor_y) - DIFF_W'($signed(s_tdata[47:24]));
    dx_abs = dx[DIFF_W-1] ? DIFF_W'(-dx) : dx;
    dy_abs = dy[DIFF_W-1] ? DIFF_W'(-dy) : dy;
  end

  always_comb begin
    hit         = (mode == MODE_CONSUME) && active && (sts.d2 <= {2'b00, consume_rsq});
    health_next = health;
    active_next = active;
    if (hit) begin
      health_next = health - $signed({2'b00, damage});
      active_next = health_next > 0;
    end else if (mode == MODE_RESTORE) begin
      health_next = $signed({2'b00, init_health});
      active_next = 1'b1;
    end
    out_free = !m_tvalid || m_tready;
  end

  assign s_tready  = (st == T_IDLE);
  assign cfg_ready = 1'b1;
  assign m_tdata   = out_data;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      attractor_x <= '0;
      attractor_y <= '0;
      attract_rsq <= RST_ATTRACT_RSQ;
      consume_rsq <= '0;
      force_gain  <= RST_FORCE_GAIN;
      init_health <= RST_INIT_HEALTH;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ATTRACTOR_X: attractor_x <= $signed(cfg_data[COORD_W-1:0]);
        REG_ATTRACTOR_Y: attractor_y <= $signed(cfg_data[COORD_W-1:0]);
        REG_ATTRACT_RSQ: attract_rsq <= cfg_data;
        REG_CONSUME_RSQ: consume_rsq <= cfg_data;
        REG_FORCE_GAIN:  force_gain  <= cfg_data[GAIN_W-1:0];
        REG_INIT_HEALTH: init_health <= cfg_data[HEALTH_W-1:0];
        default: ;
      endcase
    end
  end

  // item sequencing, health state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= T_IDLE;
      ctl.start <= 1'b0;
      m_tvalid  <= 1'b0;
      health    <= $signed({2'b00, RST_INIT_HEALTH});
      active    <= 1'b1;
    end else begin
      ctl.start <= 1'b0;
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (st)
        T_IDLE: begin
          if (s_tvalid) begin
            mode         <= s_tuser;
            damage       <= s_tdata[63:48];
            ax           <= dx_abs[COORD_W-1:0];
            ay           <= dy_abs[COORD_W-1:0];
            neg_x        <= dx[DIFF_W-1];
            neg_y        <= dy[DIFF_W-1];
            ctl.force_en <= (s_tuser == MODE_FORCE) && active;
            ctl.start    <= 1'b1;
            st           <= T_RUN;
          end
        end
        T_RUN: begin
          if (sts.done) st <= T_DONE;
        end
        T_DONE: begin
          if (out_free) begin
            health   <= health_next;
            active   <= active_next;
            out_data <= {5'd0, health_next[HNOW_W-1:0], active_next, hit,
                         eng_fy, eng_fx};
            m_tvalid <= 1'b1;
            st       <= T_IDLE;
          end
        end
        default: st <= T_IDLE;
      endcase
    end
  end

  afcu_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .ax        (ax),
    .ay        (ay),
    .neg_x     (neg_x),
    .neg_y     (neg_y),
    .radius_sq (attract_rsq),
    .gain      (force_gain),
    .sts       (sts),
    .force_x   (eng_fx),
    .force_y   (eng_fy)
  );

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the attractor force and consume unit. Items are
// queued by a stimulus process and sent by a clocked driver; every accepted
// item is run through a local predictor of the force, consume and restore
// behavior. A monitor compares each result item with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import afcu_pkg::*;

  localparam int unsigned STALL_LIMIT = 20000;
  localparam logic [1:0]  MODE_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]  mode;
    logic [23:0] ax;
    logic [23:0] ay;
    logic [15:0] dmg;
  } agent_item_t;

  typedef struct {
    logic [23:0] fx;
    logic [23:0] fy;
    logic        consumed;
    logic        active;
    logic [16:0] health;
  } attr_result_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [71:0] m_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [RADSQ_W-1:0]   cfg_data;

  // register copies and attractor state
  longint          pos_x, pos_y;
  longint unsigned rad_sq, eat_sq, gain, init_hp;
  int              hp;
  bit              alive;

  agent_item_t  pending_q[$];
  attr_result_t expected_q[$];

  int src_idle, snk_idle;
  int errors, items_sent, results_seen, hits, pulls, cfg_writes;
  int unsigned quiet_cycles;

  attractor_force_and_consume_unit u_dut (.*);

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint sext24(logic [23:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // one axis of the pull, clamped to the signed 24 bit range
  function automatic logic [23:0] pull_axis(longint unsigned m, longint d,
                                            longint unsigned len);
    longint unsigned a, q;
    longint s;
    a = (d < 0) ? longint'(-d) : d;
    q = (m * a) / len;
    if (q > 64'd8388608) q = 64'd8388608;
    s = (d < 0) ? -longint'(q) : longint'(q);
    if (s > 8388607) s = 8388607;
    if (s < -8388608) s = -8388608;
    return s[23:0];
  endfunction

  // attractor behavior for one item; updates health and active flag
  function automatic attr_result_t attract_and_consume(agent_item_t it);
    attr_result_t r;
    longint dx, dy;
    longint unsigned d2, t, m, len;
    dx = pos_x - sext24(it.ax);
    dy = pos_y - sext24(it.ay);
    d2 = dx * dx + dy * dy;
    r.fx = '0;
    r.fy = '0;
    r.consumed = 1'b0;
    if (it.mode == MODE_FORCE) begin
      if (alive && d2 != 0 && d2 < rad_sq) begin
        t = ((rad_sq - d2) << 16) / rad_sq;
        m = (t * gain) >> 16;
        len = int_sqrt(d2);
        r.fx = pull_axis(m, dx, len);
        r.fy = pull_axis(m, dy, len);
      end
    end else if (it.mode == MODE_CONSUME) begin
      if (alive && d2 <= eat_sq) begin
        hp = hp - int'(it.dmg);
        if (hp <= 0) alive = 1'b0;
        r.consumed = 1'b1;
      end
    end else if (it.mode == MODE_RESTORE) begin
      hp = int'(init_hp);
      alive = 1'b1;
    end
    r.active = alive;
    r.health = hp[16:0];
    return r;
  endfunction

  // driver: sends pending items and predicts each accepted one
  always @(posedge clk) begin
    agent_item_t it;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        it.mode = s_tuser;
        it.ax   = s_tdata[23:0];
        it.ay   = s_tdata[47:24];
        it.dmg  = s_tdata[63:48];
        expected_q.push_back(attract_and_consume(it));
        items_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= src_idle) begin
          it = pending_q.pop_front();
          s_tuser  <= it.mode;
          s_tdata  <= {it.dmg, it.ay, it.ax};
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // register copies follow accepted writes
  always @(posedge clk) begin
    if (rst) begin
      pos_x = 0;
      pos_y = 0;
      rad_sq = 64'(RST_ATTRACT_RSQ);
      eat_sq = 0;
      gain = 64'(RST_FORCE_GAIN);
      init_hp = 64'(RST_INIT_HEALTH);
      hp = int'(RST_INIT_HEALTH);
      alive = 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ATTRACTOR_X: pos_x = sext24(cfg_data[23:0]);
        REG_ATTRACTOR_Y: pos_y = sext24(cfg_data[23:0]);
        REG_ATTRACT_RSQ: rad_sq = 64'(cfg_data);
        REG_CONSUME_RSQ: eat_sq = 64'(cfg_data);
        REG_FORCE_GAIN:  gain = 64'(cfg_data[15:0]);
        REG_INIT_HEALTH: init_hp = 64'(cfg_data[15:0]);
        default: ;
      endcase
      cfg_writes <= cfg_writes + 1;
    end
  end

  // receiver and result check
  always @(posedge clk) begin
    attr_result_t e;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= snk_idle);
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result item %h", m_tdata);
        end else begin
          e = expected_q.pop_front();
          if (e.consumed) hits++;
          if (e.fx != 0 || e.fy != 0) pulls++;
          if (m_tdata[23:0] !== e.fx || m_tdata[47:24] !== e.fy ||
              m_tdata[48] !== e.consumed || m_tdata[49] !== e.active ||
              m_tdata[66:50] !== e.health) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp fx %h fy %h c %b a %b h %h, got fx %h fy %h c %b a %b h %h",
                       e.fx, e.fy, e.consumed, e.active, e.health,
                       m_tdata[23:0], m_tdata[47:24], m_tdata[48], m_tdata[49],
                       m_tdata[66:50]);
          end
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", quiet_cycles);
      $display("tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [RADSQ_W-1:0] val);
    int n;
    n = cfg_writes;
    @(posedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    wait (cfg_writes == n + 1);
    cfg_valid <= 1'b0;
  endtask

  task automatic send(logic [1:0] mode, longint x, longint y, int dmg);
    agent_item_t it;
    it.mode = mode;
    it.ax = x[23:0];
    it.ay = y[23:0];
    it.dmg = dmg[15:0];
    pending_q.push_back(it);
  endtask

  task automatic wait_idle();
    wait (pending_q.size() == 0 && !s_tvalid && expected_q.size() == 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic setup(longint x, longint y, longint unsigned r2, longint unsigned c2,
                       int g, int h);
    write_reg(REG_ATTRACTOR_X, RADSQ_W'(x[23:0]));
    write_reg(REG_ATTRACTOR_Y, RADSQ_W'(y[23:0]));
    write_reg(REG_ATTRACT_RSQ, r2[46:0]);
    write_reg(REG_CONSUME_RSQ, c2[46:0]);
    write_reg(REG_FORCE_GAIN, RADSQ_W'(g[15:0]));
    write_reg(REG_INIT_HEALTH, RADSQ_W'(h[15:0]));
  endtask

  // coordinate near a center, spread a little past the radius
  function automatic longint near(longint c, longint span);
    return c + longint'($urandom_range(32'(2 * span))) - span;
  endfunction

  initial begin
    longint cx, cy, r, span;
    int k, sel, ph, n;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    src_idle = 21;
    snk_idle = 58;
    errors = 0;
    items_sent = 0;
    results_seen = 0;
    hits = 0;
    pulls = 0;
    cfg_writes = 0;
    quiet_cycles = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset settings: tiny radius, agent on the attractor, unused mode
    send(MODE_FORCE, 0, 0, 0);
    send(MODE_FORCE, 1, 0, 0);
    send(MODE_CONSUME, 0, 0, 30);
    send(MODE_UNUSED, 5, -5, 65535);
    send(MODE_CONSUME, 1, 0, 30);
    send(MODE_CONSUME, 0, 0, 80);
    send(MODE_CONSUME, 0, 0, 10);
    send(MODE_FORCE, 0, 1, 0);
    send(MODE_RESTORE, 0, 0, 0);
    wait_idle();

    // extremes: widest radius, full gain, far corners
    setup(-8388608, 8388607, 64'h7FFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF, 65535, 65535);
    send(MODE_FORCE, 8388607, -8388608, 0);
    send(MODE_FORCE, -8388608, 8388607, 0);
    send(MODE_FORCE, -8388607, 8388607, 0);
    send(MODE_FORCE, -8388608, 0, 0);
    send(MODE_FORCE, 0, 8388607, 0);
    send(MODE_CONSUME, 8388607, 8388607, 65535);
    send(MODE_FORCE, -8388000, 8388000, 0);
    send(MODE_CONSUME, -8388608, 8388607, 1);
    send(MODE_RESTORE, 0, 0, 0);
    send(MODE_CONSUME, 0, 0, 65535);
    send(MODE_RESTORE, 0, 0, 0);
    wait_idle();
    setup(8388607, -8388608, 64'h7FFF_FFFF_FFFF, 0, 0, 1);
    send(MODE_FORCE, 0, 0, 0);
    send(MODE_CONSUME, 8388607, -8388608, 1);
    send(MODE_RESTORE, 0, 0, 0);
    wait_idle();

    // random phases with varied settings and idling
    for (ph = 0; ph < 12; ph++) begin
      if (ph == 4) begin
        src_idle = 58;
        snk_idle = 21;
      end else if (ph == 8) begin
        src_idle = 0;
        snk_idle = 0;
      end
      k = $urandom_range(23, 2);
      r = longint'(1) << k;
      r = r + longint'($urandom_range(r[31:0] - 1));
      if (r > 8388607) r = 8388607;
      cx = sext24(24'($urandom()));
      cy = sext24(24'($urandom()));
      setup(cx, cy, r * r, (r * r) >> $urandom_range(4, 0),
            (ph % 3 == 0) ? 65535 : $urandom_range(65535),
            (ph % 4 == 0) ? 1 : $urandom_range(65535, 1));
      span = r + r / 4;
      for (n = 0; n < 84; n++) begin
        sel = $urandom_range(99);
        if (sel < 8)
          send(2'($urandom_range(3)), sext24(24'($urandom())), sext24(24'($urandom())),
               $urandom());
        else if (sel < 60)
          send(MODE_FORCE, near(cx, span), near(cy, span), $urandom());
        else if (sel < 90)
          send(MODE_CONSUME, near(cx, span), near(cy, span),
               ($urandom_range(3) == 0) ? $urandom() : $urandom_range(4000));
        else
          send(MODE_RESTORE, sext24(24'($urandom())), sext24(24'($urandom())),
               $urandom());
      end
      wait_idle();
    end

    repeat (200) @(posedge clk);
    $display("covered %0d items in %0d results, %0d register writes", items_sent,
             results_seen, cfg_writes);
    $display("%0d nonzero pulls, %0d consume hits, %0d errors", pulls, hits, errors);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
